[hw/rtl/pdfsu_pkg.sv]
// types and constants shared by the literal string unescape block
package pdfsu_pkg;

  // number of results one input byte can cause at most
  localparam int RES_MAX = 3;

  // largest value the byte_count field can show
  localparam logic [15:0] SHOW_MAX = 16'hFFFF;

  // character codes
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] DIGIT_0   = 8'h30;
  localparam logic [7:0] DIGIT_9   = 8'h39;

  // result kinds
  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_CLOSED    = 2'd1,
    KIND_EXHAUSTED = 2'd2
  } kind_e;

  // escape sequencer, one-hot
  typedef enum logic [3:0] {
    PH_NORMAL     = 4'b0001,
    PH_ESCAPE     = 4'b0010,
    PH_ONE_DIGIT  = 4'b0100,
    PH_TWO_DIGITS = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       data_end;
  } pdfsu_in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    kind_e       kind;
    logic [15:0] byte_count;
    logic        last;
  } pdfsu_out_t;

endpackage

[hw/rtl/pdfsu_decode.sv]
// per-byte decode: escape handling, nesting depth and the result group
module pdfsu_decode import pdfsu_pkg::*; #(
  parameter int DEPTH_BITS = 16,
  parameter int COUNT_BITS = 16
) (
  input  pdfsu_in_t              in_i,
  input  phase_e                 phase_i,
  input  logic [DEPTH_BITS-1:0]  depth_i,
  input  logic [7:0]             held1_i,
  input  logic [7:0]             held2_i,
  input  logic [COUNT_BITS-1:0]  count_i,
  output pdfsu_out_t             res_o [RES_MAX],
  output logic [1:0]             res_cnt_o,
  output logic                   done_o,
  output phase_e                 phase_o,
  output logic [DEPTH_BITS-1:0]  depth_o,
  output logic [7:0]             held1_o,
  output logic [7:0]             held2_o,
  output logic [COUNT_BITS-1:0]  count_o
);

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    sat_inc = (c != '1) ? c + 1'b1 : c;
  endfunction

  function automatic logic [15:0] show(input logic [COUNT_BITS-1:0] c);
    logic [32:0] ext;
    ext  = 33'(c);
    show = (ext > 33'(SHOW_MAX)) ? SHOW_MAX : ext[15:0];
  endfunction

  logic [7:0]            b;
  logic                  e;
  logic                  is_dig;
  logic                  ord;
  logic                  pre_v;
  logic                  main_v;
  kind_e                 main_k;
  logic [7:0]            main_b;
  logic                  end_v;
  logic                  closed;
  logic [DEPTH_BITS-1:0] dec;
  logic [3:0]            d1;
  logic [3:0]            d2;
  logic [7:0]            dval;
  logic [COUNT_BITS-1:0] cnt;
  logic [1:0]            n;

  always_comb begin
    b      = in_i.in_byte;
    e      = in_i.data_end;
    is_dig = (b >= DIGIT_0) && (b <= DIGIT_9);
    d1     = 4'(held1_i - DIGIT_0);
    d2     = 4'(held2_i - DIGIT_0);
    dval   = {d1[1:0], 6'b0} | {1'b0, d2, 3'b0} | 8'(b - DIGIT_0);

    phase_o = PH_NORMAL;
    depth_o = depth_i;
    held1_o = held1_i;
    held2_o = held2_i;
    pre_v   = 1'b0;
    main_v  = 1'b0;
    main_k  = KIND_BYTE;
    main_b  = b;
    closed  = 1'b0;
    ord     = 1'b0;
    dec     = depth_i;

    case (phase_i)
      PH_NORMAL: begin
        ord = 1'b1;
      end
      PH_ESCAPE: begin
        case (b)
          CH_N: begin
            main_v = 1'b1;
            main_b = CH_LF;
          end
          CH_R: begin
            main_v = 1'b1;
            main_b = CH_CR;
          end
          CH_T: begin
            main_v = 1'b1;
            main_b = CH_TAB;
          end
          CH_B: begin
            main_v = 1'b1;
            main_b = CH_BS;
          end
          CH_F: begin
            main_v = 1'b1;
            main_b = CH_FF;
          end
          CH_LPAREN, CH_RPAREN, CH_BSLASH: begin
            main_v = 1'b1;
          end
          default: begin
            // first octal-style digit, else the escape is dropped
            if (is_dig && !e) begin
              held1_o = b;
              phase_o = PH_ONE_DIGIT;
            end
          end
        endcase
      end
      PH_ONE_DIGIT: begin
        if (is_dig && !e) begin
          held2_o = b;
          phase_o = PH_TWO_DIGITS;
        end else begin
          ord = 1'b1;
        end
      end
      PH_TWO_DIGITS: begin
        if (is_dig) begin
          main_v = 1'b1;
          main_b = dval;
        end else begin
          // broken escape: second digit goes out as plain data
          pre_v = 1'b1;
          ord   = 1'b1;
        end
      end
      default: begin
        ord = 1'b1;
      end
    endcase

    if (ord) begin
      if (b == CH_LPAREN) begin
        if (depth_i != '1) depth_o = depth_i + 1'b1;
        main_v = 1'b1;
      end else if (b == CH_RPAREN) begin
        if (depth_i != '0) dec = depth_i - 1'b1;
        depth_o = dec;
        main_v  = 1'b1;
        if (dec == '0) begin
          closed = 1'b1;
          main_k = KIND_CLOSED;
          main_b = 8'h00;
        end
      end else if (b == CH_BSLASH) begin
        phase_o = PH_ESCAPE;
      end else begin
        main_v = 1'b1;
      end
    end

    end_v  = e && !closed;
    done_o = closed || e;

    // pack the results in order, counting decoded bytes as they go
    for (int k = 0; k < RES_MAX; k++) res_o[k] = '0;
    n   = 2'd0;
    cnt = count_i;
    if (pre_v) begin
      cnt = sat_inc(cnt);
      res_o[n] = '{out_byte: held2_i, kind: KIND_BYTE, byte_count: show(cnt), last: 1'b0};
      n = n + 2'd1;
    end
    if (main_v) begin
      if (main_k == KIND_BYTE) cnt = sat_inc(cnt);
      res_o[n] = '{out_byte: main_b, kind: main_k, byte_count: show(cnt), last: 1'b0};
      n = n + 2'd1;
    end
    if (end_v) begin
      res_o[n] = '{out_byte: 8'h00, kind: KIND_EXHAUSTED, byte_count: show(cnt), last: 1'b0};
      n = n + 2'd1;
    end
    if (n != 2'd0) res_o[n - 2'd1].last = 1'b1;
    res_cnt_o = n;
    count_o   = cnt;

    if (done_o) begin
      phase_o = PH_NORMAL;
      depth_o = {{(DEPTH_BITS-1){1'b0}}, 1'b1};
      held1_o = 8'h00;
      held2_o = 8'h00;
      count_o = '0;
    end
  end

endmodule

[hw/rtl/pdf_literal_string_unescape_core.sv]
// top level of the literal string unescape block: state registers and result queue
//
// input channel: one raw byte of a literal string body per transfer, starting
//   after the opening parenthesis, with data_end marking the last byte of data
// output channel: one result per transfer; a decoded byte (kind 0), a closed
//   marker (kind 1) when the nesting depth falls to zero, or an exhausted
//   marker (kind 2) on a data_end byte that gives no closed marker; last marks
//   the final result caused by one input byte
// each input byte causes zero to three results; decoding is one combinational
//   pass from the state registers and the incoming byte, and the results are
//   written into a four-entry result queue at the accepting edge
// results are registered in the queue before they are offered
// throughput: one byte per cycle while each byte gives at most one result and the
//   output is not stalled; each result takes its own transfer on the output port
// input stall is a plain function of the queue fill (stall at two or more
//   queued results), so there is no path from output stall to input stall
// reset clears the decode state (depth one, normal phase, count zero) and
//   empties the queue; after a marker the state returns to the same values
// a stalled receiver holds the offered result; input stalls once the queue
//   holds two or more results
module pdf_literal_string_unescape_core import pdfsu_pkg::*; #(
  parameter int DEPTH_BITS = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  pdfsu_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output pdfsu_out_t out_data_o
);

  localparam int QDEPTH = 4;

  // decode state
  phase_e                phase_q, phase_d;
  logic [DEPTH_BITS-1:0] depth_q, depth_d;
  logic [7:0]            held1_q, held1_d;
  logic [7:0]            held2_q, held2_d;
  logic [COUNT_BITS-1:0] count_q, count_d;

  // result group of the byte at the input
  pdfsu_out_t res      [RES_MAX];
  logic [1:0] res_cnt;
  logic       done;

  // result queue
  pdfsu_out_t q_mem [QDEPTH];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [2:0] cnt_q, cnt_d;

  logic in_xfer;
  logic out_xfer;

  pdfsu_decode #(
    .DEPTH_BITS(DEPTH_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_decode (
    .in_i      (in_data_i),
    .phase_i   (phase_q),
    .depth_i   (depth_q),
    .held1_i   (held1_q),
    .held2_i   (held2_q),
    .count_i   (count_q),
    .res_o     (res),
    .res_cnt_o (res_cnt),
    .done_o    (done),
    .phase_o   (phase_d),
    .depth_o   (depth_d),
    .held1_o   (held1_d),
    .held2_o   (held2_d),
    .count_o   (count_d)
  );

  // room for a full group of three whenever at most one result is queued
  assign in_stall_o  = (cnt_q > 3'd1);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_xfer    = out_valid_o && !out_stall_i;
  assign out_data_o  = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + (in_xfer ? res_cnt : 2'd0);
    rd_ptr_d = rd_ptr_q + (out_xfer ? 2'd1 : 2'd0);
    cnt_d    = cnt_q + (in_xfer ? {1'b0, res_cnt} : 3'd0) - (out_xfer ? 3'd1 : 3'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_NORMAL;
      depth_q  <= {{(DEPTH_BITS-1){1'b0}}, 1'b1};
      held1_q  <= 8'h00;
      held2_q  <= 8'h00;
      count_q  <= '0;
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      cnt_q    <= 3'd0;
    end else begin
      if (in_xfer) begin
        phase_q <= phase_d;
        depth_q <= depth_d;
        held1_q <= held1_d;
        held2_q <= held2_d;
        count_q <= count_d;
      end
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // group entries land in consecutive queue slots
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < RES_MAX; k++) begin
      if (in_xfer && (2'(k) < res_cnt)) begin
        q_mem[wr_ptr_q + 2'(k)] <= res[k];
      end
    end
  end

  // queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'd4)
    else $error("result queue overflow");

  // nesting depth never rests at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni) depth_q != '0)
    else $error("depth register at zero");

  // a held first digit is always a decimal digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_ONE_DIGIT || phase_q == PH_TWO_DIGITS) |->
      (held1_q >= DIGIT_0 && held1_q <= DIGIT_9))
    else $error("held digit is not a digit");

  // a marker returns the decode state to its starting values
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && done) |=>
      (phase_q == PH_NORMAL && depth_q == {{(DEPTH_BITS-1){1'b0}}, 1'b1} && count_q == '0))
    else $error("state not cleared after string end");

endmodule

[verif/pdf_literal_string_unescape_core_test.sv]
// self-checking testbench for the literal string unescape block
module pdf_literal_string_unescape_core_test;
  import pdfsu_pkg::*;

  // run length guard, far beyond the slowest correct run
  localparam int CYCLE_LIMIT = 1000000;
  // random token stream length, in input bytes
  localparam int RANDOM_ITEMS = 340;
  // the depth and count registers are 16 bits wide at the default parameters
  localparam logic [15:0] DEPTH_TOP = 16'hFFFF;
  localparam int N_SCRIPT = 27;
  // cap on printed mismatch lines, every mismatch is still counted
  localparam int PRINT_CAP = 40;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid;
  logic       in_stall;
  pdfsu_in_t  in_data;
  logic       out_valid;
  logic       out_stall;
  pdfsu_out_t out_data;

  pdf_literal_string_unescape_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // one row of the directed script; typed rows carry their single result
  typedef struct packed {
    logic [7:0]  in_byte;
    logic        data_end;
    logic        typed;
    logic [7:0]  out_byte;
    kind_e       kind;
    logic [15:0] byte_count;
  } script_row_t;

  // directed script, run straight after reset
  script_row_t script [N_SCRIPT] = '{
    // plain bytes, the low and high extremes, then a nested pair
    '{"A",       1'b0, 1'b1, "A",       KIND_BYTE,      16'd1},
    '{8'h00,     1'b0, 1'b1, 8'h00,     KIND_BYTE,      16'd2},
    '{8'hFF,     1'b0, 1'b1, 8'hFF,     KIND_BYTE,      16'd3},
    '{CH_LPAREN, 1'b0, 1'b1, CH_LPAREN, KIND_BYTE,      16'd4},
    '{CH_RPAREN, 1'b0, 1'b1, CH_RPAREN, KIND_BYTE,      16'd5},
    // newline escape
    '{CH_BSLASH, 1'b0, 1'b0, 8'h00,     KIND_BYTE,      16'd0},
    '{CH_N,      1'b0, 1'b1, CH_LF,     KIND_BYTE,      16'd6},
    // unknown escape swallows both bytes
    '{CH_BSLASH, 1'b0, 1'b0, 8'h00,     KIND_BYTE,      16'd0},
    '{"q",       1'b0, 1'b0, 8'h00,     KIND_BYTE,      16'd0},
    // largest digit escape, truncated to eight bits
    '{CH_BSLASH, 1'b0, 1'b0, 8'h00,     KIND_BYTE,      16'd0},
    '{"9",       1'b0, 1'b0, 8'h00,     KIND_BYTE,      16'd0},
    '{"9",       1'b0, 1'b0, 8'h00,     KIND_BYTE,      16'd0},
    '{"9",       1'b0, 1'b1, 8'h49,     KIND_BYTE,      16'd7},
    // third byte not a digit, at data end: three results from one byte
    '{CH_BSLASH, 1'b0, 1'b0, 8'h00,     KIND_BYTE,      16'd0},
    '{"1",       1'b0, 1'b0, 8'h00,     KIND_BYTE,      16'd0},
    '{"2",       1'b0, 1'b0, 8'h00,     KIND_BYTE,      16'd0},
    '{"Z",       1'b1, 1'b0, 8'h00,     KIND_BYTE,      16'd0},
    // close and data end on the same byte gives only the closed marker
    '{CH_RPAREN, 1'b1, 1'b1, 8'h00,     KIND_CLOSED,    16'd0},
    // second digit flagged data end is taken as a plain byte
    '{CH_BSLASH, 1'b0, 1'b0, 8'h00,     KIND_BYTE,      16'd0},
    '{"5",       1'b0, 1'b0, 8'h00,     KIND_BYTE,      16'd0},
    '{"8",       1'b1, 1'b0, 8'h00,     KIND_BYTE,      16'd0},
    // first digit at data end is dropped along with the backslash
    '{CH_BSLASH, 1'b0, 1'b0, 8'h00,     KIND_BYTE,      16'd0},
    '{"7",       1'b1, 1'b1, 8'h00,     KIND_EXHAUSTED, 16'd0},
    // lone backslash at data end
    '{CH_BSLASH, 1'b1, 1'b1, 8'h00,     KIND_EXHAUSTED, 16'd0},
    // second byte not a digit: the closing paren is processed as usual
    '{CH_BSLASH, 1'b0, 1'b0, 8'h00,     KIND_BYTE,      16'd0},
    '{"3",       1'b0, 1'b0, 8'h00,     KIND_BYTE,      16'd0},
    '{CH_RPAREN, 1'b0, 1'b1, 8'h00,     KIND_CLOSED,    16'd0}
  };

  // decoder state mirror
  logic [15:0] depth_m;
  phase_e      phase_m;
  logic [7:0]  first_m;
  logic [7:0]  second_m;
  logic [15:0] count_m;
  logic        closed_m;
  pdfsu_out_t  step_res[$];

  // results still owed by the block, oldest first
  pdfsu_out_t  decoded_q[$];
  pdfsu_out_t  want_r;

  int  errors;
  int  cycles;
  int  stall_left;
  int  items_sent;
  bit  calm;

  function automatic void clear_model();
    depth_m  = 16'd1;
    phase_m  = PH_NORMAL;
    first_m  = '0;
    second_m = '0;
    count_m  = '0;
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= DIGIT_0 && b <= DIGIT_9;
  endfunction

  // append one result; at most three per byte, the count saturates
  function automatic void add_result(logic [7:0] b, kind_e k);
    pdfsu_out_t r;
    if (step_res.size() >= RES_MAX) return;
    if (k == KIND_BYTE && count_m != SHOW_MAX) count_m++;
    r.out_byte   = (k == KIND_BYTE) ? b : 8'h00;
    r.kind       = k;
    r.byte_count = count_m;
    r.last       = 1'b0;
    step_res.push_back(r);
  endfunction

  // byte outside any escape
  function automatic void plain_byte(logic [7:0] b);
    if (b == CH_LPAREN) begin
      if (depth_m != DEPTH_TOP) depth_m++;
      add_result(b, KIND_BYTE);
    end else if (b == CH_RPAREN) begin
      if (depth_m != 16'd0) depth_m--;
      if (depth_m == 16'd0) begin
        add_result(8'h00, KIND_CLOSED);
        closed_m = 1'b1;
      end else begin
        add_result(b, KIND_BYTE);
      end
    end else if (b == CH_BSLASH) begin
      phase_m = PH_ESCAPE;
    end else begin
      add_result(b, KIND_BYTE);
    end
  endfunction

  // byte right after a backslash
  function automatic void escape_byte(logic [7:0] b, logic fin);
    phase_m = PH_NORMAL;
    case (b)
      CH_N: add_result(CH_LF, KIND_BYTE);
      CH_R: add_result(CH_CR, KIND_BYTE);
      CH_T: add_result(CH_TAB, KIND_BYTE);
      CH_B: add_result(CH_BS, KIND_BYTE);
      CH_F: add_result(CH_FF, KIND_BYTE);
      CH_LPAREN, CH_RPAREN, CH_BSLASH: add_result(b, KIND_BYTE);
      default: begin
        if (is_digit(b) && !fin) begin
          first_m = b;
          phase_m = PH_ONE_DIGIT;
        end
      end
    endcase
  endfunction

  // full decode of one input byte into step_res
  function automatic void unescape_byte(pdfsu_in_t item);
    logic [7:0]  b;
    logic        fin;
    int unsigned code;
    b   = item.in_byte;
    fin = item.data_end;
    step_res.delete();
    closed_m = 1'b0;
    case (phase_m)
      PH_NORMAL: plain_byte(b);
      PH_ESCAPE: escape_byte(b, fin);
      PH_ONE_DIGIT: begin
        phase_m = PH_NORMAL;
        if (is_digit(b) && !fin) begin
          second_m = b;
          phase_m  = PH_TWO_DIGITS;
        end else begin
          plain_byte(b);
        end
      end
      default: begin
        phase_m = PH_NORMAL;
        if (is_digit(b)) begin
          code = (((32'(first_m) - 32'(DIGIT_0)) & 32'hF) << 6)
               | (((32'(second_m) - 32'(DIGIT_0)) & 32'hF) << 3)
               | (32'(b) - 32'(DIGIT_0));
          add_result(code[7:0], KIND_BYTE);
        end else begin
          // broken escape: the held second digit becomes a plain byte
          plain_byte(second_m);
          plain_byte(b);
        end
      end
    endcase
    if (!closed_m && fin) begin
      add_result(8'h00, KIND_EXHAUSTED);
      closed_m = 1'b1;
    end
    if (closed_m) clear_model();
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    if (errors <= PRINT_CAP)
      $display("mismatch in %s: got %0d, expected %0d, cycle %0d", what, got, want, cycles);
  endtask

  // idle length for either side: mostly none or short, a few long
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // offer one byte, wait for its transfer, record what it must produce
  task automatic send_item(pdfsu_in_t item, bit typed, pdfsu_out_t want);
    int gap;
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    unescape_byte(item);
    // a typed row replaces the mirror's single result, the state still advances
    if (typed) decoded_q.push_back(want);
    else foreach (step_res[i]) decoded_q.push_back(step_res[i]);
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_byte(logic [7:0] b, logic fin);
    pdfsu_in_t item;
    item.in_byte  = b;
    item.data_end = fin;
    send_item(item, 1'b0, '0);
  endtask

  // one random token: mostly well-formed escapes and parens, some noise
  task automatic random_token();
    logic [7:0] tok[$];
    logic [7:0] esc_chars [8];
    logic [7:0] nd;
    int pick;
    esc_chars = '{CH_N, CH_R, CH_T, CH_B, CH_F, CH_LPAREN, CH_RPAREN, CH_BSLASH};
    pick = $urandom_range(99);
    // a non-digit byte: flipping bit 6 moves any digit out of the digit range
    nd = 8'($urandom_range(255));
    if (is_digit(nd)) nd = nd ^ 8'h40;
    if (pick < 28) begin
      tok.push_back(8'($urandom_range(255)));
    end else if (pick < 40) begin
      tok.push_back(CH_LPAREN);
    end else if (pick < 49) begin
      tok.push_back(CH_RPAREN);
    end else if (pick < 64) begin
      tok.push_back(CH_BSLASH);
      tok.push_back(esc_chars[$urandom_range(7)]);
    end else if (pick < 80) begin
      tok.push_back(CH_BSLASH);
      repeat (3) tok.push_back(DIGIT_0 + 8'($urandom_range(9)));
    end else if (pick < 86) begin
      tok.push_back(CH_BSLASH);
      tok.push_back(DIGIT_0 + 8'($urandom_range(9)));
      tok.push_back(nd);
    end else if (pick < 92) begin
      tok.push_back(CH_BSLASH);
      repeat (2) tok.push_back(DIGIT_0 + 8'($urandom_range(9)));
      tok.push_back(nd);
    end else if (pick < 96) begin
      tok.push_back(CH_BSLASH);
      tok.push_back(8'($urandom_range(255)));
    end else begin
      tok.push_back(8'($urandom_range(255)));
    end
    // data end lands on the last byte of a token now and then, also inside escapes
    foreach (tok[i])
      send_byte(tok[i], (i == tok.size() - 1) && ($urandom_range(99) < 6));
    items_sent += tok.size();
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // cycle count and timeout
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // output side: check each transfer, then pick the next stall value
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("result with nothing pending, kind", int'(out_data.kind), -1);
      end else begin
        want_r = decoded_q.pop_front();
        if (out_data.out_byte !== want_r.out_byte)
          report_mismatch("out_byte", out_data.out_byte, want_r.out_byte);
        if (out_data.kind !== want_r.kind)
          report_mismatch("kind", int'(out_data.kind), int'(want_r.kind));
        if (out_data.byte_count !== want_r.byte_count)
          report_mismatch("byte_count", out_data.byte_count, want_r.byte_count);
        if (out_data.last !== want_r.last)
          report_mismatch("last", out_data.last, want_r.last);
      end
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      stall_left = idle_len();
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // reset and stimulus
  initial begin
    errors     = 0;
    cycles     = 0;
    stall_left = 0;
    items_sent = 0;
    calm       = 1'b0;
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_stall  = 1'b0;
    clear_model();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows
    foreach (script[i]) begin
      send_item('{in_byte: script[i].in_byte, data_end: script[i].data_end},
                script[i].typed,
                '{out_byte: script[i].out_byte, kind: script[i].kind,
                  byte_count: script[i].byte_count, last: 1'b1});
    end

    // random token stream, with calm stretches switched in and out
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(24) == 0) calm = !calm;
      random_token();
    end

    // end whatever string is open
    send_byte("x", 1'b1);
    in_valid <= 1'b0;

    // drain, then wait quietly to catch stray results
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
